// ===== design/nops_pkg.sv =====
// Shared types and constants for the normal offset patch outlier sampler.
package nops_pkg;

  localparam int unsigned MaxWidth   = 128;
  localparam int unsigned MaxHeight  = 128;
  localparam int unsigned XW         = $clog2(MaxWidth);
  localparam int unsigned YW         = $clog2(MaxHeight);
  localparam int unsigned AddrW      = XW + YW;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;

  localparam logic [1:0] StatusColour  = 2'd0;
  localparam logic [1:0] StatusOutside = 2'd1;
  localparam logic [1:0] StatusOutlier = 2'd2;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam logic FuncWrite = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StCoord,
    StTrunc,
    StCheck,
    StRead,
    StEval,
    StCmp,
    StColour
  } state_e;

endpackage

// ===== design/nops_ram.sv =====
// Generic single-port RAM with registered read.
module nops_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/normal_offset_patch_outlier_sampler.sv =====
// Top level of the normal offset patch outlier sampler.
//
// Usage: raise start with the item fields while busy is low; the item is
// taken at that edge. A write item (func_i = 0) stores one BGR and one Lab
// pixel together, gives no result and leaves busy low, so writes
// can follow back to back. A query item (func_i = 1) gives exactly one
// result on status_o/blue_o/green_o/red_o, marked by a one-cycle done_o
// strobe; the receiver cannot hold it off.
// A query forms the offset products, truncates the sample position, checks
// it, walks its clipped 3x3 patch through the Lab memory one read per cycle,
// reads the centre and compares one Lab channel per cycle, stopping at the
// first outlier channel. done_o rises in the same cycle that busy falls.
// An out-of-image sample returns to idle after the check, with no patch read.
// The image size registers sit on an APB port at byte addresses 0 (width)
// and 4 (height), both 128 after reset. Reset clears control state and the
// registers; the memories are not cleared, and every pixel must be written
// before a query reads it.
module normal_offset_patch_outlier_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [6:0]  pixel_x_i,
  input  logic [6:0]  pixel_y_i,
  input  logic [23:0] write_bgr_i,
  input  logic [23:0] write_lab_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [11:0] distance_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o
);

  localparam int unsigned XW = nops_pkg::XW;
  localparam int unsigned YW = nops_pkg::YW;
  localparam int unsigned AW = nops_pkg::AddrW;

  // configuration
  logic [7:0] width_q, height_q;
  logic       cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd128;
      height_q <= 8'd128;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[2])
        nops_pkg::RegWidth:  width_q  <= pwdata[7:0];
        nops_pkg::RegHeight: height_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        nops_pkg::RegWidth:  prdata = {24'd0, width_q};
        nops_pkg::RegHeight: prdata = {24'd0, height_q};
        default:             prdata = '0;
      endcase
    end
  end

  // effective image size, clamped to the store
  logic [8:0] w_eff, h_eff;
  assign w_eff = (width_q  < 8'(nops_pkg::MaxWidth))  ? {1'b0, width_q}
                                                      : 9'(nops_pkg::MaxWidth);
  assign h_eff = (height_q < 8'(nops_pkg::MaxHeight)) ? {1'b0, height_q}
                                                      : 9'(nops_pkg::MaxHeight);

  // state
  nops_pkg::state_e state_q, state_d;

  logic signed [15:0] px_q, py_q, nx_q, ny_q;
  logic signed [11:0] dist_q;
  logic signed [28:0] prodx_q, prody_q;
  logic signed [14:0] sx_q, sy_q;
  logic [XW-1:0] x0_q, x1_q, cx_q, ux_q;
  logic [YW-1:0] y0_q, y1_q, cy_q, uy_q;
  logic [XW-1:0] xi_q;
  logic [YW-1:0] yi_q;
  logic          rd_q;      // a patch read was issued last cycle
  logic          last_q;    // last issued read was the final patch pixel
  logic          fin_q;     // last read has returned; sums are complete
  logic          ctr_rd_q;  // centre read issued
  logic [3:0]    n_q;
  logic [11:0]   s_q [3];
  logic [19:0]   sq_q [3];
  logic [7:0]    v_q [3];
  logic [1:0]    res_status_q;
  logic [23:0]   res_bgr_q;
  logic          done_q;

  logic          accept;
  assign accept = start & ~busy;
  assign busy   = (state_q != nops_pkg::StIdle);

  // memory port
  logic          we;
  logic [AW-1:0] addr;
  logic [23:0]   lab_rd, bgr_rd;

  always_comb begin
    we   = 1'b0;
    addr = {pixel_y_i, pixel_x_i};
    if (state_q == nops_pkg::StIdle) begin
      we = accept & (func_i == nops_pkg::FuncWrite);
    end else if (state_q == nops_pkg::StRead && !last_q) begin
      addr = {yi_q, xi_q};
    end else begin
      addr = {uy_q, ux_q};
    end
  end

  nops_ram #(.Width(24), .Depth(nops_pkg::StoreDepth)) u_lab (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(write_lab_i), .rdata_o(lab_rd)
  );
  nops_ram #(.Width(24), .Depth(nops_pkg::StoreDepth)) u_bgr (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(write_bgr_i), .rdata_o(bgr_rd)
  );

  // coordinate truncation toward zero
  function automatic logic signed [14:0] trunc18(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [14:0] q;
    mag = v[32] ? 33'(-v) : 33'(v);
    q   = mag[32:18];
    return v[32] ? 15'(-q) : 15'(q);
  endfunction

  logic signed [32:0] qx, qy;
  assign qx = 33'(px_q) * 33'sd16384 + 33'(prodx_q);
  assign qy = 33'(py_q) * 33'sd16384 + 33'(prody_q);

  // sample coordinates, registered in StTrunc
  logic signed [14:0] sx_n, sy_n;
  assign sx_n = trunc18(qx);
  assign sy_n = trunc18(qy);

  logic inside_img;
  assign inside_img = !sx_q[14] && !sy_q[14]
                      && (16'(sx_q) < 16'(w_eff)) && (16'(sy_q) < 16'(h_eff));

  // outlier compare on one channel per cycle
  logic [1:0]        ch_q;
  logic              outl_q;
  logic signed [13:0] dev;
  logic signed [27:0] dev2;
  logic signed [24:0] nq;
  logic signed [24:0] ss;
  logic signed [25:0] var_s;
  assign dev   = 14'(n_q * v_q[ch_q]) - 14'(s_q[ch_q]);
  assign dev2  = dev * dev;
  assign nq    = 25'(n_q * sq_q[ch_q]);
  assign ss    = 25'(s_q[ch_q] * s_q[ch_q]);
  assign var_s = 26'(nq) - 26'(ss);

  always_comb begin
    state_d = state_q;
    case (state_q)
      nops_pkg::StIdle:
        if (accept && func_i != nops_pkg::FuncWrite) state_d = nops_pkg::StCoord;
      nops_pkg::StCoord: state_d = nops_pkg::StTrunc;
      nops_pkg::StTrunc: state_d = nops_pkg::StCheck;
      nops_pkg::StCheck:
        state_d = inside_img ? nops_pkg::StRead : nops_pkg::StIdle;
      nops_pkg::StRead:  if (fin_q && ctr_rd_q) state_d = nops_pkg::StEval;
      nops_pkg::StEval:  state_d = nops_pkg::StCmp;
      nops_pkg::StCmp:
        if (outl_q || ch_q == 2'd2) state_d = nops_pkg::StColour;
      nops_pkg::StColour: state_d = nops_pkg::StIdle;
      default: state_d = nops_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nops_pkg::StIdle;
      done_q  <= 1'b0;
      rd_q    <= 1'b0;
      last_q  <= 1'b0;
      fin_q   <= 1'b0;
      ctr_rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        nops_pkg::StCheck: begin
          done_q   <= !inside_img;
          rd_q     <= 1'b0;
          last_q   <= 1'b0;
          fin_q    <= 1'b0;
          ctr_rd_q <= 1'b0;
        end
        nops_pkg::StRead: begin
          rd_q <= !last_q;
          if (!last_q) last_q <= (xi_q == x1_q) && (yi_q == y1_q);
          else ctr_rd_q <= 1'b1;
          if (last_q && !rd_q) fin_q <= 1'b1;
          if (last_q && rd_q) fin_q <= 1'b1;
        end
        nops_pkg::StColour: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      nops_pkg::StIdle: begin
        px_q <= point_x_i; py_q <= point_y_i;
        nx_q <= normal_x_i; ny_q <= normal_y_i;
        dist_q <= distance_i;
      end
      nops_pkg::StCoord: begin
        prodx_q <= 29'(dist_q) * 29'(nx_q);
        prody_q <= 29'(dist_q) * 29'(ny_q);
      end
      nops_pkg::StTrunc: begin
        sx_q <= sx_n;
        sy_q <= sy_n;
      end
      default: ;
    endcase
    if (state_q == nops_pkg::StCheck) begin
      res_status_q <= nops_pkg::StatusOutside;
      res_bgr_q    <= '0;
      x0_q <= (sx_q == 15'sd0) ? '0 : XW'(sx_q - 15'sd1);
      x1_q <= (16'(sx_q) == 16'(w_eff) - 16'd1) ? XW'(sx_q) : XW'(sx_q + 15'sd1);
      y0_q <= (sy_q == 15'sd0) ? '0 : YW'(sy_q - 15'sd1);
      y1_q <= (16'(sy_q) == 16'(h_eff) - 16'd1) ? YW'(sy_q) : YW'(sy_q + 15'sd1);
      xi_q <= (sx_q == 15'sd0) ? '0 : XW'(sx_q - 15'sd1);
      yi_q <= (sy_q == 15'sd0) ? '0 : YW'(sy_q - 15'sd1);
      ux_q <= XW'(sx_q);
      uy_q <= YW'(sy_q);
      n_q  <= 4'(((sx_q == 15'sd0 ? 0 : 1) + 1 +
                  (16'(sx_q) == 16'(w_eff) - 16'd1 ? 0 : 1)) *
                 ((sy_q == 15'sd0 ? 0 : 1) + 1 +
                  (16'(sy_q) == 16'(h_eff) - 16'd1 ? 0 : 1)));
      for (int c = 0; c < 3; c++) begin
        s_q[c]  <= '0;
        sq_q[c] <= '0;
      end
    end
    if (state_q == nops_pkg::StRead && !last_q) begin
      if (xi_q == x1_q) begin
        xi_q <= x0_q;
        yi_q <= yi_q + YW'(1);
      end else begin
        xi_q <= xi_q + XW'(1);
      end
    end
    if (rd_q) begin
      for (int c = 0; c < 3; c++) begin
        s_q[c]  <= s_q[c] + 12'(lab_rd[8*c +: 8]);
        sq_q[c] <= sq_q[c] + 20'(lab_rd[8*c +: 8] * lab_rd[8*c +: 8]);
      end
    end
    if (state_q == nops_pkg::StEval) begin
      for (int c = 0; c < 3; c++) v_q[c] <= lab_rd[8*c +: 8];
      ch_q   <= 2'd0;
      outl_q <= 1'b0;
    end
    if (state_q == nops_pkg::StCmp && !outl_q) begin
      outl_q <= (28'(var_s) < dev2) && !var_s[25] || var_s[25];
      ch_q   <= ch_q + 2'd1;
    end
    if (state_q == nops_pkg::StColour) begin
      res_status_q <= outl_q ? nops_pkg::StatusOutlier : nops_pkg::StatusColour;
      res_bgr_q    <= outl_q ? 24'd0 : bgr_rd;
    end
  end

  assign done_o   = done_q;
  assign status_o = res_status_q;
  assign blue_o   = res_bgr_q[7:0];
  assign green_o  = res_bgr_q[15:8];
  assign red_o    = res_bgr_q[23:16];

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the normal offset patch outlier sampler.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        func;
    logic [6:0]  px;
    logic [6:0]  py;
    logic [23:0] bgr;
    logic [23:0] lab;
    logic [15:0] ptx;
    logic [15:0] pty;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [11:0] travel;
  } pixel_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } sample_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [6:0]  pixel_x_i = '0;
  logic [6:0]  pixel_y_i = '0;
  logic [23:0] write_bgr_i = '0;
  logic [23:0] write_lab_i = '0;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic signed [15:0] normal_x_i = '0;
  logic signed [15:0] normal_y_i = '0;
  logic signed [11:0] distance_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  blue_o;
  logic [7:0]  green_o;
  logic [7:0]  red_o;

  normal_offset_patch_outlier_sampler u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .func_i, .pixel_x_i, .pixel_y_i, .write_bgr_i, .write_lab_i,
    .point_x_i, .point_y_i, .normal_x_i, .normal_y_i, .distance_i,
    .done_o, .status_o, .blue_o, .green_o, .red_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pixel_cmd_t  cmd_q[$];
  sample_res_t sample_q[$];
  bit [23:0]   colour_mem[nops_pkg::StoreDepth];
  bit [23:0]   lab_mem[nops_pkg::StoreDepth];
  bit          planned[nops_pkg::StoreDepth];
  int unsigned cfg_width = 128;
  int unsigned cfg_height = 128;
  int          err_count = 0;
  logic        beat_taken = 1'b0;
  int          burst_left = 5;
  int          gap_left = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint offset_coord(logic signed [15:0] p, logic signed [11:0] d,
                                          logic signed [15:0] nrm);
    longint q;
    q = longint'(p) * 16384 + longint'(d) * longint'(nrm);
    if (q < 0) return -((-q) >>> 18);
    return q >>> 18;
  endfunction

  function automatic int unsigned used_width();
    return (cfg_width < nops_pkg::MaxWidth) ? cfg_width : nops_pkg::MaxWidth;
  endfunction

  function automatic int unsigned used_height();
    return (cfg_height < nops_pkg::MaxHeight) ? cfg_height : nops_pkg::MaxHeight;
  endfunction

  function automatic sample_res_t predict_sample(pixel_cmd_t c);
    sample_res_t r;
    longint sx, sy, w, h, x0, x1, y0, y1, n, v, dev;
    longint sum[3], sq[3];
    bit [23:0] lab;
    bit outlier;
    r = '{nops_pkg::StatusColour, 8'd0, 8'd0, 8'd0};
    w = used_width();
    h = used_height();
    sx = offset_coord(c.ptx, c.travel, c.nx);
    sy = offset_coord(c.pty, c.travel, c.ny);
    if (sx < 0 || sx >= w || sy < 0 || sy >= h) begin
      r.status = nops_pkg::StatusOutside;
      return r;
    end
    x0 = (sx == 0) ? 0 : sx - 1;
    x1 = (sx == w - 1) ? w - 1 : sx + 1;
    y0 = (sy == 0) ? 0 : sy - 1;
    y1 = (sy == h - 1) ? h - 1 : sy + 1;
    n = (x1 - x0 + 1) * (y1 - y0 + 1);
    for (int k = 0; k < 3; k++) begin
      sum[k] = 0;
      sq[k] = 0;
    end
    for (longint y = y0; y <= y1; y++) begin
      for (longint x = x0; x <= x1; x++) begin
        lab = lab_mem[y * nops_pkg::MaxWidth + x];
        for (int k = 0; k < 3; k++) begin
          v = longint'(lab[8*k +: 8]);
          sum[k] += v;
          sq[k] += v * v;
        end
      end
    end
    lab = lab_mem[sy * nops_pkg::MaxWidth + sx];
    outlier = 1'b0;
    for (int k = 0; k < 3; k++) begin
      v = longint'(lab[8*k +: 8]);
      dev = n * v - sum[k];
      if (dev * dev > n * sq[k] - sum[k] * sum[k]) outlier = 1'b1;
    end
    if (outlier) begin
      r.status = nops_pkg::StatusOutlier;
      return r;
    end
    lab = colour_mem[sy * nops_pkg::MaxWidth + sx];
    r.blue = lab[7:0];
    r.green = lab[15:8];
    r.red = lab[23:16];
    return r;
  endfunction

  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t c;
    c.func = 1'b1;
    c.px = 7'($urandom);
    c.py = 7'($urandom);
    c.bgr = 24'($urandom);
    c.lab = 24'($urandom);
    c.ptx = 16'($urandom);
    c.pty = 16'($urandom);
    c.nx = 16'($urandom_range(32768) - 16384);
    c.ny = 16'($urandom_range(32768) - 16384);
    c.travel = 12'($urandom);
    return c;
  endfunction

  task automatic push_pixel(input int x, input int y, input logic [23:0] lab);
    pixel_cmd_t c;
    c = random_cmd();
    c.func = nops_pkg::FuncWrite;
    c.px = 7'(x);
    c.py = 7'(y);
    c.lab = lab;
    planned[y * nops_pkg::MaxWidth + x] = 1'b1;
    cmd_q.push_back(c);
  endtask

  // Write any patch pixel not yet loaded; smooth=1 reloads the patch near one base.
  task automatic push_query(input pixel_cmd_t c, input bit smooth);
    longint sx, sy, w, h;
    logic [23:0] base, lab;
    w = used_width();
    h = used_height();
    sx = offset_coord(c.ptx, c.travel, c.nx);
    sy = offset_coord(c.pty, c.travel, c.ny);
    base = 24'($urandom);
    if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
      for (longint y = sy - 1; y <= sy + 1; y++) begin
        for (longint x = sx - 1; x <= sx + 1; x++) begin
          if (x >= 0 && x < w && y >= 0 && y < h &&
              (smooth || !planned[y * nops_pkg::MaxWidth + x])) begin
            lab = smooth ? base + {7'd0, 1'($urandom_range(1)), 7'd0,
                                   1'($urandom_range(1)), 7'd0,
                                   1'($urandom_range(1))} : 24'($urandom);
            push_pixel(int'(x), int'(y), lab);
          end
        end
      end
    end
    cmd_q.push_back(c);
  endtask

  // Aim the start point so the sample lands in the middle of cell (tx, ty).
  task automatic push_aimed(input int tx, input int ty, input logic [15:0] nx,
                            input logic [15:0] ny, input logic [11:0] d, input bit smooth);
    pixel_cmd_t c;
    c = random_cmd();
    c.nx = nx;
    c.ny = ny;
    c.travel = d;
    c.ptx = 16'((longint'(tx) * 262144 + 131072
                 - longint'($signed(d)) * longint'($signed(nx))) >>> 14);
    c.pty = 16'((longint'(ty) * 262144 + 131072
                 - longint'($signed(d)) * longint'($signed(ny))) >>> 14);
    push_query(c, smooth);
  endtask

  task automatic fill_random(input int count);
    int w, h, tx, ty;
    for (int i = 0; i < count; i++) begin
      w = used_width();
      h = used_height();
      case ($urandom_range(9))
        0: push_query(random_cmd(), 1'b0);
        1: begin
          tx = $urandom_range(nops_pkg::MaxWidth - 1);
          ty = $urandom_range(nops_pkg::MaxHeight - 1);
          push_pixel(tx, ty, 24'($urandom));
        end
        default: begin
          tx = (w == 0) ? $urandom_range(3) : $urandom_range(w - 1);
          ty = (h == 0) ? $urandom_range(3) : $urandom_range(h - 1);
          if ($urandom_range(3) == 0 && w > 0) tx = $urandom_range(1) ? 0 : w - 1;
          if ($urandom_range(3) == 0 && h > 0) ty = $urandom_range(1) ? 0 : h - 1;
          if ($urandom_range(7) == 0) tx = $urandom_range(1) ? -1 : w;
          push_aimed(tx, ty, 16'($urandom_range(32768) - 16384),
                     16'($urandom_range(32768) - 16384), 12'($urandom),
                     $urandom_range(2) == 0);
        end
      endcase
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || start || sample_q.size() != 0 || busy);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == nops_pkg::RegWidth) cfg_width = {24'd0, value[7:0]};
    else cfg_height = {24'd0, value[7:0]};
  endtask

  task automatic run_phase(input int wv, input int hv, input int count);
    apb_write(nops_pkg::RegWidth, 32'(wv));
    apb_write(nops_pkg::RegHeight, 32'(hv));
    fill_random(count);
    drain();
  endtask

  // Sender: bursts with random gaps; hold an offered beat until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !beat_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        pixel_pop();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic pixel_pop();
    pixel_cmd_t c;
    c = cmd_q.pop_front();
    start <= 1'b1;
    func_i <= c.func;
    pixel_x_i <= c.px;
    pixel_y_i <= c.py;
    write_bgr_i <= c.bgr;
    write_lab_i <= c.lab;
    point_x_i <= c.ptx;
    point_y_i <= c.pty;
    normal_x_i <= c.nx;
    normal_y_i <= c.ny;
    distance_i <= c.travel;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  // Monitor: check results, then take the accepted beat into the model.
  always @(posedge clk_i) begin
    pixel_cmd_t  c;
    sample_res_t e;
    if (!rst_ni) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (done_o) begin
        if (sample_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, status %0d", status_o));
        end else begin
          e = sample_q.pop_front();
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
          if (blue_o !== e.blue)
            report_mismatch($sformatf("blue %0h, want %0h", blue_o, e.blue));
          if (green_o !== e.green)
            report_mismatch($sformatf("green %0h, want %0h", green_o, e.green));
          if (red_o !== e.red)
            report_mismatch($sformatf("red %0h, want %0h", red_o, e.red));
        end
      end
      if (start && !busy) begin
        if (func_i == nops_pkg::FuncWrite) begin
          colour_mem[{pixel_y_i, pixel_x_i}] = write_bgr_i;
          lab_mem[{pixel_y_i, pixel_x_i}] = write_lab_i;
        end else begin
          c.ptx = point_x_i;
          c.pty = point_y_i;
          c.nx = normal_x_i;
          c.ny = normal_y_i;
          c.travel = distance_i;
          sample_q.push_back(predict_sample(c));
        end
      end
    end
  end

  initial begin
    pixel_cmd_t c;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, edges, field extremes, outside on every side.
    push_aimed(0, 0, 16'sd16384, 16'sd0, 12'sd0, 1'b1);
    push_aimed(127, 127, -16'sd16384, 16'sd16384, 12'sd2047, 1'b0);
    push_aimed(0, 127, 16'sd0, -16'sd16384, -12'sd2048, 1'b1);
    push_aimed(127, 0, 16'sd11585, 16'sd11585, 12'sd100, 1'b0);
    push_aimed(64, 64, -16'sd11585, 16'sd11585, -12'sd37, 1'b1);
    push_aimed(64, 65, 16'sd0, 16'sd0, 12'sd5, 1'b0);
    push_aimed(-1, 10, 16'sd16384, 16'sd0, 12'sd16, 1'b0);
    push_aimed(10, 128, 16'sd0, 16'sd16384, -12'sd16, 1'b0);
    push_aimed(128, 3, 16'sd0, 16'sd0, 12'sd0, 1'b0);
    push_aimed(5, -1, 16'sd0, 16'sd0, 12'sd0, 1'b0);
    c = random_cmd();
    c.ptx = 16'h7fff;
    c.pty = 16'h8000;
    push_query(c, 1'b0);
    c = random_cmd();
    c.ptx = 16'h8000;
    c.pty = 16'h7fff;
    c.travel = 12'h800;
    push_query(c, 1'b0);
    // Slightly negative offsets truncate to zero, not to minus one.
    c = random_cmd();
    c.ptx = -16'sd8;
    c.pty = -16'sd1;
    c.travel = 12'sd0;
    push_query(c, 1'b0);
    push_pixel(127, 0, 24'hffffff);
    push_pixel(0, 0, 24'h000000);
    drain();

    fill_random(50);
    drain();
    run_phase(255, 200, 40);
    run_phase(1, 1, 20);
    run_phase(3, 5, 30);
    run_phase(0, 10, 20);
    run_phase(40, 0, 20);
    run_phase(128, 1, 30);
    run_phase(2, 128, 30);
    run_phase($urandom_range(1, 128), $urandom_range(1, 128), 50);
    run_phase(128, 128, 30);

    repeat (40) @(negedge clk_i);
    if (err_count == 0 && sample_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sample_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", sample_q.size()));
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
